>>> design/substring_search_stream_top_defines.svh
// Assertion macros used by the substring search top level.
`ifndef SUBSTRING_SEARCH_STREAM_TOP_DEFINES_SVH
`define SUBSTRING_SEARCH_STREAM_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a condition on every clock edge outside reset.
`define SSRCH_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a trigger is followed in the next cycle by a consequence.
`define SSRCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSRCH_ASSERT(lbl, cond, msg)
`define SSRCH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/ssrch_pkg.sv
// Types, constants and register codes of the substring search block.
package ssrch_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int WIN_DEPTH   = MAX_PATTERN - 1;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 5;
  localparam int POS_W       = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;

  localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
  localparam logic [IDX_W-1:0] LEN_M1_MAX = IDX_W'(MAX_PATTERN - 1);

  typedef logic [7:0] byte_t;
  typedef byte_t pat_t [MAX_PATTERN];

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LO  = 8'd0,
    REG_PATTERN_HI  = 8'd1,
    REG_PATTERN_LEN = 8'd2,
    REG_SEARCH_LAST = 8'd3
  } cfg_reg_t;

  // Decoded configuration seen by the search logic.
  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] pattern;
    logic [IDX_W-1:0]            len_m1;
    logic                        search_last;
  } cfg_t;

  // Window control handed to every cell.
  typedef struct packed {
    logic adv;
    logic clr;
  } ctl_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_start;
  } res_t;

endpackage

>>> design/ssrch_if.sv
// Handshake interfaces for the text, result and configuration channels.
interface ssrch_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  text_byte;
  logic        end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface ssrch_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [ssrch_pkg::POS_W-1:0]  match_start;
  modport source (output valid, found, match_start, input ready);
  modport sink   (input valid, found, match_start, output ready);
endinterface

interface ssrch_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ssrch_pkg::CFG_IDX_W-1:0]   index;
  logic [ssrch_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/ssrch_cfg.sv
// Configuration registers and decode of the effective pattern length.
module ssrch_cfg (
  input  logic              clk,
  input  logic              rst_n,
  ssrch_cfg_if.sink         cfg_chan,
  output ssrch_pkg::cfg_t   cfg
);

  logic [63:0]                   pat_lo_r, pat_lo_nxt;
  logic [63:0]                   pat_hi_r, pat_hi_nxt;
  logic [ssrch_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic                          last_r, last_nxt;
  logic [127:0]                  pat_full;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    pat_lo_nxt = pat_lo_r;
    pat_hi_nxt = pat_hi_r;
    len_nxt    = len_r;
    last_nxt   = last_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        ssrch_pkg::REG_PATTERN_LO:  pat_lo_nxt = cfg_chan.data;
        ssrch_pkg::REG_PATTERN_HI:  pat_hi_nxt = cfg_chan.data;
        ssrch_pkg::REG_PATTERN_LEN: len_nxt    = cfg_chan.data[ssrch_pkg::LEN_W-1:0];
        ssrch_pkg::REG_SEARCH_LAST: last_nxt   = cfg_chan.data[0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      len_r    <= ssrch_pkg::LEN_W'(1);
      last_r   <= 1'b0;
    end else begin
      pat_lo_r <= pat_lo_nxt;
      pat_hi_r <= pat_hi_nxt;
      len_r    <= len_nxt;
      last_r   <= last_nxt;
    end
  end

  assign pat_full = {pat_hi_r, pat_lo_r};

  always_comb begin
    for (int j = 0; j < ssrch_pkg::MAX_PATTERN; j++) begin
      cfg.pattern[j] = pat_full[8*j +: 8];
    end
    // Zero length acts as one, anything above the maximum is clamped.
    if (len_r == '0) begin
      cfg.len_m1 = '0;
    end else if (len_r > ssrch_pkg::LEN_W'(ssrch_pkg::MAX_PATTERN)) begin
      cfg.len_m1 = ssrch_pkg::LEN_M1_MAX;
    end else begin
      cfg.len_m1 = ssrch_pkg::IDX_W'(len_r - ssrch_pkg::LEN_W'(1));
    end
    cfg.search_last = last_r;
  end

endmodule

>>> design/ssrch_cell.sv
// One window cell: holds an earlier text byte and compares it to its pattern byte.
module ssrch_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ssrch_pkg::IDX_W-1:0]  cell_idx,
  input  ssrch_pkg::ctl_t              ctl,
  input  ssrch_pkg::byte_t             din,
  input  logic [ssrch_pkg::MAX_PATTERN-1:0][7:0] pattern,
  input  logic [ssrch_pkg::IDX_W-1:0]  len_m1,
  output ssrch_pkg::byte_t             dout,
  output logic                         eq
);

  ssrch_pkg::byte_t             byte_r, byte_nxt;
  logic                         active;
  logic [ssrch_pkg::IDX_W-1:0]  pidx;

  // Advance from the neighbor; drop the byte at the end of a text.
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.adv) begin
      byte_nxt = ctl.clr ? '0 : din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign active = cell_idx < len_m1;
  assign pidx   = len_m1 - cell_idx - ssrch_pkg::IDX_W'(1);
  assign eq     = !active || (byte_r == pattern[pidx]);
  assign dout   = byte_r;

endmodule

>>> design/substring_search_stream_top.sv
// Top level of the streaming substring search block.
//
//   channel   | dir | payload                     | request accepted when
//   ----------+-----+-----------------------------+----------------------
//   in_chan   | in  | text_byte, end_of_text      | valid && ready
//   out_chan  | out | found, match_start          | valid && ready
//   cfg_chan  | in  | index, data                 | valid && ready (ready tied high)
//
// One text byte is taken every cycle while in_chan is ready; the whole pattern window is
// compared combinationally across a row of fifteen cells plus the incoming byte.
// The result of a text is registered when its last byte is taken, into the skid slot if out_chan stalls.
// Two result slots (output register and skid register) sit behind the window, so
// in_chan drops ready only while both slots hold results that are not yet taken.
// Reset is synchronous and active low; no clearing pass is needed after it.
`include "substring_search_stream_top_defines.svh"

module substring_search_stream_top (
  input  logic        clk,
  input  logic        rst_n,
  ssrch_in_if.sink    in_chan,
  ssrch_out_if.source out_chan,
  ssrch_cfg_if.sink   cfg_chan
);

  ssrch_pkg::cfg_t  cfg;
  ssrch_pkg::ctl_t  ctl;
  ssrch_pkg::byte_t cell_din  [ssrch_pkg::WIN_DEPTH];
  ssrch_pkg::byte_t cell_dout [ssrch_pkg::WIN_DEPTH];
  logic [ssrch_pkg::WIN_DEPTH-1:0] cell_eq;

  // Per-text search state.
  logic [ssrch_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        seen_r, seen_nxt;
  logic [ssrch_pkg::POS_W-1:0] idx_r, idx_nxt;

  // Result slots.
  ssrch_pkg::res_t out_res_r, out_res_nxt;
  logic            out_valid_r, out_valid_nxt;
  ssrch_pkg::res_t skid_res_r, skid_res_nxt;
  logic            skid_valid_r, skid_valid_nxt;

  logic                        accept;
  logic                        push;
  logic                        pop;
  logic                        cur_eq;
  logic                        pos_ok;
  logic                        hit;
  logic                        take;
  logic                        seen_upd;
  logic [ssrch_pkg::POS_W-1:0] idx_upd;
  ssrch_pkg::res_t             res_new;

  ssrch_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // Hold the window while idle, shift on every accepted byte, clear at end of text.
  assign accept  = in_chan.valid && in_chan.ready;
  assign ctl.adv = accept;
  assign ctl.clr = in_chan.end_of_text;

  // Row of cells: cell 0 holds the byte just before the current one.
  for (genvar k = 0; k < ssrch_pkg::WIN_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_din[k] = in_chan.text_byte;
    end else begin : g_link
      assign cell_din[k] = cell_dout[k-1];
    end
    ssrch_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (ssrch_pkg::IDX_W'(k)),
      .ctl      (ctl),
      .din      (cell_din[k]),
      .pattern  (cfg.pattern),
      .len_m1   (cfg.len_m1),
      .dout     (cell_dout[k]),
      .eq       (cell_eq[k])
    );
  end

  // The incoming byte lines up with the last pattern byte.
  assign cur_eq = in_chan.text_byte == cfg.pattern[cfg.len_m1];
  // Enough bytes of this text seen to fill the pattern.
  assign pos_ok = pos_r >= ssrch_pkg::POS_W'(cfg.len_m1);
  assign hit    = !ovf_r && pos_ok && cur_eq && (&cell_eq);
  // Last-match mode overwrites; first-match mode keeps the earliest.
  assign take   = hit && (cfg.search_last || !seen_r);

  assign seen_upd = seen_r || take;
  assign idx_upd  = take ? (pos_r - ssrch_pkg::POS_W'(cfg.len_m1)) : idx_r;

  assign res_new.found       = seen_upd;
  assign res_new.match_start = seen_upd ? idx_upd : '0;

  always_comb begin
    pos_nxt  = pos_r;
    ovf_nxt  = ovf_r;
    seen_nxt = seen_r;
    idx_nxt  = idx_r;
    if (accept) begin
      if (in_chan.end_of_text) begin
        // Drop all text state once the result is formed.
        pos_nxt  = '0;
        ovf_nxt  = 1'b0;
        seen_nxt = 1'b0;
        idx_nxt  = '0;
      end else begin
        seen_nxt = seen_upd;
        idx_nxt  = idx_upd;
        if (!ovf_r) begin
          // Stop counting at the last index; later matches are ignored.
          if (pos_r == ssrch_pkg::POS_MAX) begin
            ovf_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + ssrch_pkg::POS_W'(1);
          end
        end
      end
    end
  end

  // Two-slot result buffer: the skid slot catches a result while the output
  // register is stalled, and ready drops only once the skid slot is full.
  assign in_chan.ready = !skid_valid_r;
  assign push          = accept && in_chan.end_of_text;
  assign pop           = out_valid_r && out_chan.ready;

  always_comb begin
    out_res_nxt    = out_res_r;
    out_valid_nxt  = out_valid_r;
    skid_res_nxt   = skid_res_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_res_nxt   = res_new;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = res_new;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      ovf_r        <= 1'b0;
      seen_r       <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      ovf_r        <= ovf_nxt;
      seen_r       <= seen_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = out_res_r.found;
  assign out_chan.match_start = out_res_r.match_start;

  `SSRCH_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid slot full while output empty")
  `SSRCH_ASSERT_NEXT(a_eot_gives_result, push, out_valid_r, "no result after last byte")
  `SSRCH_ASSERT_NEXT(a_eot_clears_text, push, pos_r == '0 && !ovf_r && !seen_r, "text state not cleared")
  `SSRCH_ASSERT(a_ovf_at_limit, !ovf_r || pos_r == ssrch_pkg::POS_MAX, "overflow below index limit")
  `SSRCH_ASSERT(a_match_not_past_pos, !seen_r || idx_r <= pos_r, "recorded match beyond position")

endmodule

>>> tb/sv/ssrch_match_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the substring search block: predicts each text's result and compares it.
module ssrch_match_checker (
  input  logic clk,
  input  logic rst_n,
  ssrch_in_if  in_mon,
  ssrch_out_if out_mon,
  ssrch_cfg_if cfg_mon,
  output int   fail_count,
  output int   pending_results,
  output int   texts_checked
);

  localparam int TEXT_LIMIT = 1 << ssrch_pkg::POS_W;

  // Register copies.
  logic [7:0]                  pattern_bytes [ssrch_pkg::MAX_PATTERN];
  logic [ssrch_pkg::LEN_W-1:0] pattern_len_q;
  logic                        report_last;

  // Per-text search state.
  logic [7:0]                  window_bytes [ssrch_pkg::WIN_DEPTH];
  logic [ssrch_pkg::POS_W-1:0] text_pos;
  logic                        pos_capped;
  logic                        match_seen_q;
  logic [ssrch_pkg::POS_W-1:0] match_at;

  ssrch_pkg::res_t expected_results [$];
  int              mismatches = 0;
  int              compared   = 0;

  assign fail_count      = mismatches;
  assign texts_checked   = compared;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int active_len();
    if (pattern_len_q == 0) return 1;
    if (pattern_len_q > ssrch_pkg::MAX_PATTERN) return ssrch_pkg::MAX_PATTERN;
    return int'(pattern_len_q);
  endfunction

  task automatic clear_text();
    foreach (window_bytes[i]) window_bytes[i] = 8'h00;
    text_pos     = '0;
    pos_capped   = 1'b0;
    match_seen_q = 1'b0;
    match_at     = '0;
  endtask

  task automatic apply_reg_write(input logic [ssrch_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [ssrch_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ssrch_pkg::REG_PATTERN_LO: begin
        for (int k = 0; k < 8; k++) pattern_bytes[k] = data[8*k +: 8];
      end
      ssrch_pkg::REG_PATTERN_HI: begin
        for (int k = 0; k < 8; k++) pattern_bytes[8+k] = data[8*k +: 8];
      end
      ssrch_pkg::REG_PATTERN_LEN: pattern_len_q = data[ssrch_pkg::LEN_W-1:0];
      ssrch_pkg::REG_SEARCH_LAST: report_last = data[0];
      default: ;
    endcase
  endtask

  // Compare the incoming byte plus the window against the pattern, then shift.
  task automatic advance_text(input logic [7:0] cur, input logic last_byte);
    int              n;
    bit              hit;
    logic [7:0]      t;
    ssrch_pkg::res_t res;
    n = active_len();
    if (!pos_capped && (int'(text_pos) + 1 >= n)) begin
      hit = 1'b1;
      for (int k = 0; k < n; k++) begin
        t = (k == 0) ? cur : window_bytes[k-1];
        if (t != pattern_bytes[n-1-k]) hit = 1'b0;
      end
      if (hit && (report_last || !match_seen_q)) begin
        match_seen_q = 1'b1;
        match_at     = ssrch_pkg::POS_W'(int'(text_pos) + 1 - n);
      end
    end
    for (int i = ssrch_pkg::WIN_DEPTH - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
    window_bytes[0] = cur;
    if (!pos_capped) begin
      if (int'(text_pos) + 1 >= TEXT_LIMIT) pos_capped = 1'b1;
      else text_pos = text_pos + 1'b1;
    end
    if (last_byte) begin
      res.found       = match_seen_q;
      res.match_start = match_seen_q ? match_at : '0;
      expected_results.push_back(res);
      clear_text();
    end
  endtask

  task automatic check_result(input logic found,
                              input logic [ssrch_pkg::POS_W-1:0] start);
    ssrch_pkg::res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no text closed, found", found, 0);
    end else begin
      want = expected_results.pop_front();
      compared++;
      if (found !== want.found) report_mismatch("found", found, want.found);
      if (start !== want.match_start) report_mismatch("match_start", start, want.match_start);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (pattern_bytes[k]) pattern_bytes[k] = 8'h00;
      pattern_len_q = ssrch_pkg::LEN_W'(1);
      report_last   = 1'b0;
      clear_text();
      expected_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) apply_reg_write(cfg_mon.index, cfg_mon.data);
      if (out_mon.valid && out_mon.ready) check_result(out_mon.found, out_mon.match_start);
      if (in_mon.valid && in_mon.ready) advance_text(in_mon.text_byte, in_mon.end_of_text);
    end
    pending_results = expected_results.size();
  end

endmodule

>>> tb/sv/tb_substring_search_stream_top.sv
`timescale 1ns / 1ps
// Top-level testbench for the streaming substring search block.
module tb_substring_search_stream_top;

  // Stop the run after this many cycles with no request moving on any channel.
  localparam int WATCHDOG_LIMIT = 2000;
  // Random text bytes per idling phase; three phases make up the random part.
  localparam int PHASE_BYTES = 297;
  // Texts sent between two random reconfigurations.
  localparam int TEXTS_PER_CONFIG = 6;
  // First register index that the block does not decode.
  localparam logic [ssrch_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = ssrch_pkg::CFG_IDX_W'(4);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ssrch_in_if  in_chan ();
  ssrch_out_if out_chan ();
  ssrch_cfg_if cfg_chan ();

  int fail_count;
  int pending_results;
  int texts_checked;

  // Idling percentages of the current phase.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  // Stimulus-side copy of the pattern, used to plant matches in the texts.
  logic [7:0] stim_pat [ssrch_pkg::MAX_PATTERN];
  int         stim_len = 1;

  int bytes_sent = 0;
  int reg_writes = 0;
  int stall_cycles = 0;

  substring_search_stream_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  ssrch_match_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .cfg_mon         (cfg_chan),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .texts_checked   (texts_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: decide ready once per cycle at the falling edge.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles in which no request is accepted on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request accepted for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_results);
        $display("FAIL substring_search_stream_top");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Offer one text byte at a falling edge, idling first if the dice say so,
  // and return at the rising edge where the request is taken.
  task automatic push_text_byte(input logic [7:0] b, input logic last_byte);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.text_byte   <= b;
    in_chan.end_of_text <= last_byte;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_string(input string s, input bit close_text);
    for (int i = 0; i < s.len(); i++)
      push_text_byte(s[i], close_text && (i == s.len() - 1));
  endtask

  // Drop the text channel and let the block drain before touching registers.
  task automatic settle_block();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (pending_results == 0);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; keep the stimulus copy of the pattern in step.
  task automatic write_reg(input logic [ssrch_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ssrch_pkg::CFG_DATA_W-1:0] data);
    logic [ssrch_pkg::LEN_W-1:0] l;
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    reg_writes++;
    case (idx)
      ssrch_pkg::REG_PATTERN_LO: begin
        for (int k = 0; k < 8; k++) stim_pat[k] = data[8*k +: 8];
      end
      ssrch_pkg::REG_PATTERN_HI: begin
        for (int k = 0; k < 8; k++) stim_pat[8+k] = data[8*k +: 8];
      end
      ssrch_pkg::REG_PATTERN_LEN: begin
        l = data[ssrch_pkg::LEN_W-1:0];
        stim_len = (l == 0) ? 1 :
                   (l > ssrch_pkg::MAX_PATTERN) ? ssrch_pkg::MAX_PATTERN : int'(l);
      end
      default: ;
    endcase
  endtask

  // Pattern byte from a narrow alphabet so that partial matches are common,
  // or a fully random one when the spread is zero.
  function automatic logic [7:0] alphabet_byte(input int spread);
    if (spread == 0) return 8'($urandom);
    return 8'h41 + 8'($urandom_range(0, spread));
  endfunction

  task automatic random_config();
    logic [ssrch_pkg::CFG_DATA_W-1:0] lo;
    logic [ssrch_pkg::CFG_DATA_W-1:0] hi;
    logic [ssrch_pkg::CFG_DATA_W-1:0] len_word;
    logic [ssrch_pkg::CFG_DATA_W-1:0] mode_word;
    int spread;
    int r;
    spread = $urandom_range(0, 3);
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = alphabet_byte(spread);
      hi[8*k +: 8] = alphabet_byte(spread);
    end
    // Mostly legal lengths, short ones favored; sometimes zero or oversize.
    r = $urandom_range(0, 19);
    len_word = {$urandom, $urandom};
    if (r == 0) begin
      len_word[ssrch_pkg::LEN_W-1:0] = '0;
    end else if (r == 1) begin
      len_word[ssrch_pkg::LEN_W-1:0] =
        ssrch_pkg::LEN_W'($urandom_range(ssrch_pkg::MAX_PATTERN + 1, 31));
    end else if (r < 8) begin
      len_word[ssrch_pkg::LEN_W-1:0] = ssrch_pkg::LEN_W'($urandom_range(1, 3));
    end else begin
      len_word[ssrch_pkg::LEN_W-1:0] =
        ssrch_pkg::LEN_W'($urandom_range(1, ssrch_pkg::MAX_PATTERN));
    end
    mode_word = {$urandom, $urandom};
    write_reg(ssrch_pkg::REG_PATTERN_LO, lo);
    write_reg(ssrch_pkg::REG_PATTERN_HI, hi);
    if ($urandom_range(0, 3) == 0)
      write_reg(ssrch_pkg::CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, 255)),
                {$urandom, $urandom});
    write_reg(ssrch_pkg::REG_PATTERN_LEN, len_word);
    write_reg(ssrch_pkg::REG_SEARCH_LAST, mode_word);
  endtask

  // Build a text with planted pattern copies (some corrupted), or pure noise.
  task automatic send_random_text();
    logic [7:0] txt [80];
    int  len;
    int  copies;
    int  p;
    bit  noise;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 80) : $urandom_range(1, 30);
    noise = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      if (noise || $urandom_range(0, 3) == 0) txt[i] = 8'($urandom);
      else txt[i] = stim_pat[$urandom_range(0, stim_len - 1)];
    end
    if (!noise && len >= stim_len) begin
      copies = $urandom_range(0, 2);
      for (int c = 0; c < copies; c++) begin
        p = $urandom_range(0, len - stim_len);
        for (int j = 0; j < stim_len; j++) txt[p+j] = stim_pat[j];
        if ($urandom_range(0, 3) == 0)
          txt[p + $urandom_range(0, stim_len - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end
    end
    for (int i = 0; i < len; i++) push_text_byte(txt[i], i == len - 1);
  endtask

  initial begin
    int phase_start;
    int texts;

    in_chan.valid       = 1'b0;
    in_chan.text_byte   = 8'h00;
    in_chan.end_of_text = 1'b0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.index      = '0;
    cfg_chan.data       = '0;
    foreach (stim_pat[k]) stim_pat[k] = 8'h00;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // ---- Directed part, under the first idling mix ----
    send_gap_pct   = 18;
    recv_stall_pct = 60;

    // Reset pattern is a single zero byte: one hit, one miss.
    push_text_byte(8'h00, 1'b1);
    push_text_byte(8'hFF, 1'b1);

    // Three-byte pattern; the length field arrives with garbage in the upper bits.
    settle_block();
    write_reg(ssrch_pkg::REG_PATTERN_LO, 64'h0000_0000_0063_6261);
    write_reg(ssrch_pkg::REG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFE3);
    send_string("xabcabc", 1'b1);
    // Text shorter than the pattern.
    send_string("ab", 1'b1);

    // Report-last mode, flipped back to first-match halfway through a text.
    settle_block();
    write_reg(ssrch_pkg::REG_SEARCH_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
    send_string("abcab", 1'b0);
    settle_block();
    write_reg(ssrch_pkg::REG_SEARCH_LAST, 64'hFFFF_FFFF_FFFF_FFFE);
    send_string("c", 1'b1);

    // Zero length acts as one; an undecoded index must change nothing.
    settle_block();
    write_reg(ssrch_pkg::REG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
    write_reg(ssrch_pkg::CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, 255)),
              64'hFFFF_FFFF_FFFF_FFFF);
    send_string("ba", 1'b1);

    // Oversize length clamps to the full sixteen bytes: all-ones then all-zeros.
    settle_block();
    write_reg(ssrch_pkg::REG_PATTERN_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(ssrch_pkg::REG_PATTERN_HI, 64'h0000_0000_0000_0000);
    write_reg(ssrch_pkg::REG_PATTERN_LEN, 64'h0000_0000_0000_001F);
    for (int i = 0; i < 16; i++) push_text_byte((i < 8) ? 8'hFF : 8'h00, i == 15);

    // ---- Random part: three idling mixes ----
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct   = (ph == 0) ? 18 : (ph == 1) ? 60 : 0;
      recv_stall_pct = (ph == 0) ? 60 : (ph == 1) ? 18 : 0;
      phase_start = bytes_sent;
      texts = 0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if (texts % TEXTS_PER_CONFIG == 0) begin
          settle_block();
          random_config();
        end
        send_random_text();
        texts++;
      end
    end

    // Drain: wait out every outstanding result, then a few spare cycles.
    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (pending_results == 0);
    repeat (8) @(posedge clk);

    $display("Run covered %0d text bytes in %0d texts and %0d register writes,",
             bytes_sent, texts_checked, reg_writes);
    $display("directed length and mode cases, then three idling mixes of random texts.");
    if (fail_count == 0) begin
      $display("PASS substring_search_stream_top");
    end else begin
      $display("FAIL substring_search_stream_top");
    end
    $finish;
  end

endmodule
